FILE: rtl/core/pcg_rde_pkg.sv
package pcg_rde_pkg;

    // word and multiplier geometry
    localparam int WORD_BITS = 64;
    localparam int HALF_BITS = WORD_BITS / 2;
    localparam int CHUNK_BITS = 8;
    localparam int CHUNKS = WORD_BITS / CHUNK_BITS;

    // generator constants
    localparam logic [WORD_BITS-1:0] LCG_MUL = 64'h5851_F42D_4C95_7F2D;
    localparam logic [WORD_BITS-1:0] RXS_MUL = 64'hAEF1_7502_108E_F2D9;
    localparam int ROT_POS = 59;
    localparam int ROT_BASE = 5;
    localparam int OUT_SHIFT = 43;

    // register reset values
    localparam logic [WORD_BITS-1:0] SEED_RESET = 64'd0;
    localparam logic [WORD_BITS-1:0] INC_RESET = 64'd1;

    localparam int DEFAULT_TRIAL_BITS = 16;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEED = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INCREMENT = 2'd1;

    typedef enum logic [1:0] {
        MODE_RAW      = 2'd0,
        MODE_RANGE    = 2'd1,
        MODE_BIASED   = 2'd2,
        MODE_BINOMIAL = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_PROB   = 2'd1,
        STATUS_BAD_BOUNDS = 2'd2
    } status_t;

    // request to the draw unit
    typedef struct packed {
        logic                 start;
        logic [WORD_BITS-1:0] state;
        logic [WORD_BITS-1:0] increment;
    } draw_req_t;

    // response from the draw unit
    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [WORD_BITS-1:0] value;
        logic [WORD_BITS-1:0] next_state;
    } draw_rsp_t;

endpackage

FILE: rtl/core/pcg_rde_if.sv
// request channel
interface pcg_rde_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] lower_bound;
    logic [63:0] upper_bound;
    logic [63:0] prob_numerator;
    logic [6:0]  prob_exponent;
    logic [15:0] trial_count;

    modport source (
        output valid, mode, lower_bound, upper_bound, prob_numerator,
               prob_exponent, trial_count,
        input  ready
    );
    modport sink (
        input  valid, mode, lower_bound, upper_bound, prob_numerator,
               prob_exponent, trial_count,
        output ready
    );
endinterface

// result channel
interface pcg_rde_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [1:0]  status;

    modport source (
        output valid, value, status,
        input  ready
    );
    modport sink (
        input  valid, value, status,
        output ready
    );
endinterface

// register write channel
interface pcg_rde_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: rtl/core/pcg_rde_draw.sv
module pcg_rde_draw (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pcg_rde_pkg::draw_req_t req,
    output pcg_rde_pkg::draw_rsp_t rsp
);

    // one step per partial product, accumulation runs one step behind
    typedef enum logic [2:0] {
        STEP_L_LL,
        STEP_L_HL,
        STEP_L_LH,
        STEP_R_LL,
        STEP_R_HL,
        STEP_R_LH,
        STEP_R_ACC,
        STEP_FIN
    } step_t;

    localparam int W = pcg_rde_pkg::WORD_BITS;
    localparam int H = pcg_rde_pkg::HALF_BITS;

    logic  busy_reg, busy_next;
    step_t step_reg, step_next;

    logic [W-1:0] s_reg;
    logic [W-1:0] x_reg;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] f_reg, f_next;
    logic [W-1:0] prod_reg;

    logic [H-1:0] mul_a, mul_b;
    logic [W-1:0] mul_p;
    logic [W-1:0] prod_hi;
    logic [6:0]   rot;
    logic [W-1:0] xs;

    // input permutation of the old state
    assign rot = 7'(req.state[W-1:pcg_rde_pkg::ROT_POS]) + 7'(pcg_rde_pkg::ROT_BASE);
    assign xs  = (req.state >> rot) ^ req.state;

    // shared 32x32 multiplier
    assign mul_p   = mul_a * mul_b;
    assign prod_hi = {prod_reg[H-1:0], {H{1'b0}}};

    // operand selection and accumulation
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        acc_next  = acc_reg;
        f_next    = f_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        unique case (step_reg)
            STEP_L_LL:
            begin
                mul_a     = s_reg[H-1:0];
                mul_b     = pcg_rde_pkg::LCG_MUL[H-1:0];
                step_next = STEP_L_HL;
            end
            STEP_L_HL:
            begin
                mul_a     = s_reg[W-1:H];
                mul_b     = pcg_rde_pkg::LCG_MUL[H-1:0];
                acc_next  = acc_reg + prod_reg;
                step_next = STEP_L_LH;
            end
            STEP_L_LH:
            begin
                mul_a     = s_reg[H-1:0];
                mul_b     = pcg_rde_pkg::LCG_MUL[W-1:H];
                acc_next  = acc_reg + prod_hi;
                step_next = STEP_R_LL;
            end
            STEP_R_LL:
            begin
                mul_a     = x_reg[H-1:0];
                mul_b     = pcg_rde_pkg::RXS_MUL[H-1:0];
                acc_next  = acc_reg + prod_hi;
                step_next = STEP_R_HL;
            end
            STEP_R_HL:
            begin
                mul_a     = x_reg[W-1:H];
                mul_b     = pcg_rde_pkg::RXS_MUL[H-1:0];
                f_next    = prod_reg;
                step_next = STEP_R_LH;
            end
            STEP_R_LH:
            begin
                mul_a     = x_reg[H-1:0];
                mul_b     = pcg_rde_pkg::RXS_MUL[W-1:H];
                f_next    = f_reg + prod_hi;
                step_next = STEP_R_ACC;
            end
            STEP_R_ACC:
            begin
                f_next    = f_reg + prod_hi;
                step_next = STEP_FIN;
            end
            STEP_FIN:
            begin
                busy_next = 1'b0;
            end
            default:
            begin
                busy_next = 1'b0;
            end
        endcase
        if (!busy_reg)
        begin
            step_next = step_reg;
            busy_next = 1'b0;
        end
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_L_LL;
            acc_next  = req.increment | W'(1);
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_L_LL;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            s_reg <= req.state;
            x_reg <= xs;
        end
        acc_reg  <= acc_next;
        f_reg    <= f_next;
        prod_reg <= mul_p;
    end

    // output permutation
    assign rsp.busy       = busy_reg;
    assign rsp.done       = busy_reg && (step_reg == STEP_FIN);
    assign rsp.value      = f_reg ^ (f_reg >> pcg_rde_pkg::OUT_SHIFT);
    assign rsp.next_state = acc_reg;

    // checks
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("draw started while busy");

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> ##8 rsp.done)
        else $error("draw did not finish in eight cycles");

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> !busy_reg)
        else $error("draw unit still busy after done");

endmodule

FILE: rtl/core/pcg_random_draw_engine.sv
// Each draw is issued and then runs on the shared 32x32 multiplier
// (three partial products for each of the two 64-bit products).
// A bounded range redraws until a masked candidate falls in range; a biased word skips
// the low zero bits of the numerator without a draw and draws for each further bit;
// binomial builds such a word per 64 trials and popcounts each one. One request at a time.
// Reset clears the generator state to 0 and the increment to 1; no clearing pass.
module pcg_random_draw_engine #(
    parameter int TRIAL_BITS = pcg_rde_pkg::DEFAULT_TRIAL_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    pcg_rde_req_if.sink        req,
    pcg_rde_rsp_if.source      rsp,
    pcg_rde_cfg_if.sink        cfg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MASK,
        ST_SCAN,
        ST_DRAW,
        ST_POP,
        ST_DONE
    } state_t;

    localparam int W = pcg_rde_pkg::WORD_BITS;
    localparam int CB = pcg_rde_pkg::CHUNK_BITS;
    localparam logic [2:0] CHUNK_LAST = 3'(pcg_rde_pkg::CHUNKS - 1);
    localparam logic [6:0] EXPO_MAX = 7'(W);

    // bit smear below the top set bit
    function automatic logic [W-1:0] smear(input logic [W-1:0] v);
        logic [W-1:0] m;
        m = v;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        m = m | (m >> 16);
        m = m | (m >> 32);
        return m;
    endfunction

    // ones in one chunk
    function automatic logic [3:0] pop_chunk(input logic [CB-1:0] b);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < CB; i++)
            c = c + 4'(b[i]);
        return c;
    endfunction

    // control state
    state_t       state_reg, state_next;
    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] gen_state_reg, gen_state_next;
    logic [W-1:0] inc_reg, inc_next;

    // item payload and working registers
    pcg_rde_pkg::mode_t   mode_reg, mode_next;
    logic [W-1:0]         lo_reg, lo_next;
    logic [W-1:0]         hi_reg, hi_next;
    logic [W-1:0]         num_reg, num_next;
    logic [W-1:0]         num_sh_reg, num_sh_next;
    logic [6:0]           expo_reg, expo_next;
    logic [6:0]           p_reg, p_next;
    logic                 started_reg, started_next;
    logic [W-1:0]         acc_reg, acc_next;
    logic [W-1:0]         span_reg, span_next;
    logic [W-1:0]         mask_reg, mask_next;
    logic [TRIAL_BITS-1:0] trials_reg, trials_next;
    logic [TRIAL_BITS-1:0] count_reg, count_next;
    logic [2:0]           chunk_reg, chunk_next;
    logic                 last_reg, last_next;
    logic [W-1:0]         res_value_reg, res_value_next;
    pcg_rde_pkg::status_t res_status_reg, res_status_next;
    logic [W-1:0]         out_value_reg, out_value_next;
    pcg_rde_pkg::status_t out_status_reg, out_status_next;

    pcg_rde_pkg::draw_req_t draw_req;
    pcg_rde_pkg::draw_rsp_t draw_rsp;
    logic                   draw_start;

    logic [W-1:0]          cand;
    logic [TRIAL_BITS-1:0] count_sum;
    logic [6:0]            tail_shift;
    logic [31:0]           trials_ext;

    assign cand       = draw_rsp.value & mask_reg;
    assign count_sum  = count_reg + TRIAL_BITS'(pop_chunk(acc_reg[CB-1:0]));
    assign tail_shift = EXPO_MAX - trials_reg[6:0];
    assign trials_ext = 32'(req.trial_count);

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        gen_state_next  = gen_state_reg;
        inc_next        = inc_reg;
        mode_next       = mode_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        num_next        = num_reg;
        num_sh_next     = num_sh_reg;
        expo_next       = expo_reg;
        p_next          = p_reg;
        started_next    = started_reg;
        acc_next        = acc_reg;
        span_next       = span_reg;
        mask_next       = mask_reg;
        trials_next     = trials_reg;
        count_next      = count_reg;
        chunk_next      = chunk_reg;
        last_next       = last_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        draw_start      = 1'b0;

        // result taken downstream
        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next   = pcg_rde_pkg::mode_t'(req.mode);
                    lo_next     = req.lower_bound;
                    hi_next     = req.upper_bound;
                    num_next    = req.prob_numerator;
                    expo_next   = (req.prob_exponent > EXPO_MAX) ? EXPO_MAX
                                                                 : req.prob_exponent;
                    trials_next = trials_ext[TRIAL_BITS-1:0];
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                res_value_next  = '0;
                res_status_next = pcg_rde_pkg::STATUS_OK;
                acc_next        = '0;
                p_next          = '0;
                started_next    = 1'b0;
                num_sh_next     = num_reg;
                count_next      = '0;
                span_next       = hi_reg - lo_reg;
                unique case (mode_reg)
                    pcg_rde_pkg::MODE_RAW:
                    begin
                        draw_start = 1'b1;
                        state_next = ST_DRAW;
                    end
                    pcg_rde_pkg::MODE_RANGE:
                    begin
                        if (lo_reg >= hi_reg)
                        begin
                            res_status_next = pcg_rde_pkg::STATUS_BAD_BOUNDS;
                            state_next      = ST_DONE;
                        end
                        else
                            state_next = ST_MASK;
                    end
                    pcg_rde_pkg::MODE_BIASED:
                    begin
                        if (num_reg == '0)
                        begin
                            res_status_next = pcg_rde_pkg::STATUS_BAD_PROB;
                            state_next      = ST_DONE;
                        end
                        else
                            state_next = ST_SCAN;
                    end
                    pcg_rde_pkg::MODE_BINOMIAL:
                    begin
                        if ((num_reg == '0) || (trials_reg == '0))
                        begin
                            res_status_next = pcg_rde_pkg::STATUS_BAD_PROB;
                            state_next      = ST_DONE;
                        end
                        else
                            state_next = ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_MASK:
            begin
                // (re)issue a masked draw for the bounded range
                mask_next  = smear(span_reg);
                draw_start = 1'b1;
                state_next = ST_DRAW;
            end
            ST_SCAN:
            begin
                if (p_reg >= expo_reg)
                begin
                    // biased word complete
                    if (mode_reg == pcg_rde_pkg::MODE_BIASED)
                    begin
                        res_value_next = acc_reg;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        if (trials_reg > TRIAL_BITS'(W))
                        begin
                            trials_next = trials_reg - TRIAL_BITS'(W);
                            last_next   = 1'b0;
                        end
                        else
                        begin
                            acc_next  = acc_reg >> tail_shift[5:0];
                            last_next = 1'b1;
                        end
                        chunk_next = '0;
                        state_next = ST_POP;
                    end
                end
                else if (started_reg || num_sh_reg[0])
                begin
                    draw_start = 1'b1;
                    state_next = ST_DRAW;
                end
                else
                begin
                    // low zero bits of the numerator make no draw
                    p_next      = p_reg + 7'd1;
                    num_sh_next = num_sh_reg >> 1;
                end
            end
            ST_DRAW:
            begin
                if (draw_rsp.done)
                begin
                    gen_state_next = draw_rsp.next_state;
                    unique case (mode_reg)
                        pcg_rde_pkg::MODE_RAW:
                        begin
                            res_value_next = draw_rsp.value;
                            state_next     = ST_DONE;
                        end
                        pcg_rde_pkg::MODE_RANGE:
                        begin
                            if (cand <= span_reg)
                            begin
                                res_value_next = cand + lo_reg;
                                state_next     = ST_DONE;
                            end
                            else
                                state_next = ST_MASK;
                        end
                        pcg_rde_pkg::MODE_BIASED, pcg_rde_pkg::MODE_BINOMIAL:
                        begin
                            acc_next     = num_sh_reg[0] ? (acc_reg | draw_rsp.value)
                                                         : (acc_reg & draw_rsp.value);
                            p_next       = p_reg + 7'd1;
                            num_sh_next  = num_sh_reg >> 1;
                            started_next = 1'b1;
                            state_next   = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                // popcount one chunk per cycle
                count_next = count_sum;
                acc_next   = acc_reg >> CB;
                chunk_next = chunk_reg + 3'd1;
                if (chunk_reg == CHUNK_LAST)
                begin
                    if (last_reg)
                    begin
                        res_value_next = W'(count_sum);
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        acc_next     = '0;
                        p_next       = '0;
                        started_next = 1'b0;
                        num_sh_next  = num_reg;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // register writes
        if (cfg.valid)
        begin
            unique case (cfg.index)
                pcg_rde_pkg::REG_SEED:      gen_state_next = cfg.data;
                pcg_rde_pkg::REG_INCREMENT: inc_next       = cfg.data;
                default:                    ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            gen_state_reg <= pcg_rde_pkg::SEED_RESET;
            inc_reg       <= pcg_rde_pkg::INC_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            gen_state_reg <= gen_state_next;
            inc_reg       <= inc_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        num_reg        <= num_next;
        num_sh_reg     <= num_sh_next;
        expo_reg       <= expo_next;
        p_reg          <= p_next;
        started_reg    <= started_next;
        acc_reg        <= acc_next;
        span_reg       <= span_next;
        mask_reg       <= mask_next;
        trials_reg     <= trials_next;
        count_reg      <= count_next;
        chunk_reg      <= chunk_next;
        last_reg       <= last_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    // draw unit
    assign draw_req.start     = draw_start;
    assign draw_req.state     = gen_state_reg;
    assign draw_req.increment = inc_reg;

    pcg_rde_draw u_draw (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (draw_req),
        .rsp   (draw_rsp)
    );

    assign rsp.valid  = out_valid_reg;
    assign rsp.value  = out_value_reg;
    assign rsp.status = out_status_reg;

    // checks
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != pcg_rde_pkg::STATUS_OK)) |-> (rsp.value == '0))
        else $error("error result with nonzero value");

    a_range_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DRAW) && (mode_reg == pcg_rde_pkg::MODE_RANGE) &&
         draw_rsp.done && (cand <= span_reg))
        |=> ((res_value_reg >= $past(lo_reg)) && (res_value_reg <= $past(hi_reg))))
        else $error("bounded result outside range");

    a_state_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(gen_state_reg)
        |-> $past(draw_rsp.done || (cfg.valid && (cfg.index == pcg_rde_pkg::REG_SEED))))
        else $error("generator state changed without draw or seed write");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        draw_rsp.done |-> (state_reg == ST_DRAW))
        else $error("draw finished while not awaited");

endmodule
